### design/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg - shared types and constants of the masked byte pattern scanner
// Item formats, configuration register map and reset values.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int OFFSET_BITS_DEF       = 32;

	// fixed register widths
	localparam int PATTERN_BYTES  = 16;
	localparam int CARE_BITS      = 16;
	localparam int LENGTH_BITS    = 5;
	localparam int ADDR_BITS      = 64;
	localparam int COUNT_BITS     = 32;
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_CARE_MASK      = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_FIRST_ONLY     = 3'd4,
		REG_BASE_ADDRESS   = 3'd5
	} cfg_reg_t;

	localparam logic [CARE_BITS-1:0]   CARE_MASK_RST      = 16'hFFFF;
	localparam logic [LENGTH_BITS-1:0] PATTERN_LENGTH_RST = 5'd1;

	typedef struct packed {
		logic [7:0] scanned_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic                  match_found;
		logic [31:0]           match_offset;
		logic [ADDR_BITS-1:0]  match_address;
		logic                  region_done;
		logic [COUNT_BITS-1:0] match_count;
	} out_item_t;

	typedef struct packed {
		logic [8*PATTERN_BYTES-1:0] pattern;
		logic [CARE_BITS-1:0]       care_mask;
		logic [LENGTH_BITS-1:0]     pattern_length;
		logic                       first_only;
		logic [ADDR_BITS-1:0]       base_address;
	} cfg_t;

	// control of the window stage as seen by the compare stage
	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctrl_t;

endpackage

### design/mbps_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_window - input stage of the scanner
// Shifts each accepted byte into the window and keeps the region byte count.
// ----------------------------------------------------------------------------
module mbps_window #(
	parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mbps_pkg::in_item_t             in_data,
	input  logic                           advance,
	output logic [8*MAX_PATTERN_BYTES-1:0] window,
	output logic [OFFSET_BITS-1:0]         bytes_seen,
	output mbps_pkg::stage_ctrl_t          ctrl_s1
);
	import mbps_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	logic [8*MAX_PATTERN_BYTES-1:0] window_q;
	logic [OFFSET_BITS-1:0]         bytes_seen_q;
	logic                           restart_q;
	stage_ctrl_t                    ctrl_q;
	logic                           take;
	logic [OFFSET_BITS-1:0]         seen_base;

	assign in_stall  = ctrl_q.valid && !advance;
	assign take      = in_valid && !in_stall;
	assign seen_base = restart_q ? '0 : bytes_seen_q;

	// older bytes need no clearing: the compare waits until the count covers the pattern
	if (MAX_PATTERN_BYTES > 1) begin : g_shift
		always_ff @(posedge clk) begin
			if (take) begin
				window_q <= {window_q[8*MAX_PATTERN_BYTES-9:0], in_data.scanned_byte};
			end
		end
	end else begin : g_single
		always_ff @(posedge clk) begin
			if (take) begin
				window_q <= in_data.scanned_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			restart_q    <= 1'b0;
			ctrl_q       <= '0;
		end else if (take) begin
			bytes_seen_q <= (seen_base == OFFSET_MAX) ? seen_base : seen_base + 1'b1;
			// start the count afresh on the item after the last one
			restart_q    <= in_data.last_byte;
			ctrl_q.valid <= 1'b1;
			ctrl_q.last  <= in_data.last_byte;
		end else if (advance) begin
			ctrl_q.valid <= 1'b0;
		end
	end

	assign window     = window_q;
	assign bytes_seen = bytes_seen_q;
	assign ctrl_s1    = ctrl_q;

endmodule

### design/mbps_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match - compare stage and result register of the scanner
// Masked window compare, match counting and the registered result item.
// ----------------------------------------------------------------------------
module mbps_match #(
	parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mbps_pkg::cfg_t                 cfg,
	input  logic [8*MAX_PATTERN_BYTES-1:0] window,
	input  logic [OFFSET_BITS-1:0]         bytes_seen,
	input  mbps_pkg::stage_ctrl_t          ctrl_s1,
	output logic                           advance,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mbps_pkg::out_item_t            out_data
);
	import mbps_pkg::*;

	localparam int LEN_BITS     = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int WIN_IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	// pattern bytes past the register width are wildcards and drop out
	localparam int CMP_BYTES    = (MAX_PATTERN_BYTES < PATTERN_BYTES) ?
	                              MAX_PATTERN_BYTES : PATTERN_BYTES;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [LEN_BITS-1:0]   len_n;
	logic                  window_hit;
	logic                  report;
	logic [OFFSET_BITS-1:0] start;
	logic [ADDR_BITS-1:0]  start_ext;
	logic [COUNT_BITS-1:0] matches_seen_q;
	logic [COUNT_BITS-1:0] count_next;
	logic                  first_reported_q;
	logic                  out_valid_s2;
	out_item_t             out_data_s2;

	always_comb begin
		if (cfg.pattern_length == '0) begin
			len_n = LEN_BITS'(1);
		end else if (32'(cfg.pattern_length) > MAX_PATTERN_BYTES) begin
			len_n = LEN_BITS'(MAX_PATTERN_BYTES);
		end else begin
			len_n = LEN_BITS'(cfg.pattern_length);
		end
	end

	// pattern byte k pairs with the window byte n-1-k places behind the newest
	always_comb begin
		logic [LEN_BITS-1:0] idx;
		window_hit = 1'b1;
		for (int k = 0; k < CMP_BYTES; k++) begin
			idx = len_n - LEN_BITS'(k) - LEN_BITS'(1);
			if (k < int'(len_n) && cfg.care_mask[k] &&
			    window[8*idx[WIN_IDX_BITS-1:0] +: 8] != cfg.pattern[8*k +: 8]) begin
				window_hit = 1'b0;
			end
		end
	end

	assign start     = bytes_seen - OFFSET_BITS'(len_n);
	assign start_ext = ADDR_BITS'(start);
	assign report    = ctrl_s1.valid && (bytes_seen >= OFFSET_BITS'(len_n)) && window_hit &&
	                   !(cfg.first_only && first_reported_q);
	assign count_next = (report && matches_seen_q != COUNT_MAX) ?
	                    matches_seen_q + 1'b1 : matches_seen_q;

	assign advance = !out_valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2     <= 1'b0;
			matches_seen_q   <= '0;
			first_reported_q <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= report || (ctrl_s1.valid && ctrl_s1.last);
			if (ctrl_s1.valid) begin
				// drop the region state once its last item is through
				if (ctrl_s1.last) begin
					matches_seen_q   <= '0;
					first_reported_q <= 1'b0;
				end else begin
					matches_seen_q   <= count_next;
					first_reported_q <= first_reported_q || report;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctrl_s1.valid) begin
			out_data_s2.match_found   <= report;
			out_data_s2.match_offset  <= report ? start_ext[31:0] : '0;
			out_data_s2.match_address <= report ? cfg.base_address + start_ext : '0;
			out_data_s2.region_done   <= ctrl_s1.last;
			out_data_s2.match_count   <= count_next;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

### design/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner - wildcard byte signature search
// Scans a region byte by byte for a masked pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while the output does not stall, with no gaps
// between items or regions; an accepted byte passes through the window stage
// and then the result register before its result shows. The window stage
// registers the shifted window and byte count, and the masked compare, count
// update and 64-bit address add sit between that stage and the result
// register, which also lets the next byte in while a result waits. Bytes that
// neither match nor end a region give no result item. Configuration writes
// are meant for idle periods and apply to the next byte.
module masked_byte_pattern_scanner #(
	parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  mbps_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output mbps_pkg::out_item_t                   out_data,
	input  logic                                  cfg_we,
	input  logic [mbps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mbps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import mbps_pkg::*;

	cfg_t                           cfg_q;
	logic [8*MAX_PATTERN_BYTES-1:0] window;
	logic [OFFSET_BITS-1:0]         bytes_seen;
	stage_ctrl_t                    ctrl_s1;
	logic                           advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern        <= '0;
			cfg_q.care_mask      <= CARE_MASK_RST;
			cfg_q.pattern_length <= PATTERN_LENGTH_RST;
			cfg_q.first_only     <= 1'b0;
			cfg_q.base_address   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW: begin
					cfg_q.pattern[63:0] <= cfg_data;
				end
				REG_PATTERN_HIGH: begin
					cfg_q.pattern[127:64] <= cfg_data;
				end
				REG_CARE_MASK: begin
					cfg_q.care_mask <= cfg_data[CARE_BITS-1:0];
				end
				REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[LENGTH_BITS-1:0];
				end
				REG_FIRST_ONLY: begin
					cfg_q.first_only <= cfg_data[0];
				end
				REG_BASE_ADDRESS: begin
					cfg_q.base_address <= cfg_data;
				end
				default: begin
					// unmapped index: ignore the write
				end
			endcase
		end
	end

	mbps_window #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.OFFSET_BITS       (OFFSET_BITS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.advance    (advance),
		.window     (window),
		.bytes_seen (bytes_seen),
		.ctrl_s1    (ctrl_s1)
	);

	mbps_match #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.OFFSET_BITS       (OFFSET_BITS)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.window     (window),
		.bytes_seen (bytes_seen),
		.ctrl_s1    (ctrl_s1),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

### bench/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner - self-checking bench for the pattern scanner
// Streams byte regions through the scanner under varying pattern, care mask,
// length, first-only and base address settings, predicts every match and done
// item in a behavioural model, and compares each output item field by field.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_scanner;
	import mbps_pkg::*;

	localparam int WINDOW      = MAX_PATTERN_BYTES_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 4;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	in_item_t                  in_data   = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	out_item_t                 out_data;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_PATTERN_LOW;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	masked_byte_pattern_scanner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// scanner model: configuration copy and per-region state
	logic [8*PATTERN_BYTES-1:0] pattern_bits;
	logic [CARE_BITS-1:0]       care_bits;
	logic [LENGTH_BITS-1:0]     length_reg;
	logic                       first_mode;
	logic [ADDR_BITS-1:0]       base_addr;
	logic [7:0]                 win_bytes [WINDOW];
	logic [31:0]                byte_count;
	logic [COUNT_BITS-1:0]      hit_count;
	logic                       first_hit;

	in_item_t  bytes_pending [$];
	out_item_t results_due [$];

	logic in_taken     = 1'b0;
	bit   in_gaps_on   = 1'b0;
	bit   out_gaps_on  = 1'b0;
	int   in_gap       = 0;
	int   out_gap      = 0;
	int   hold_left    = 0;
	int   quiet_cycles = 0;
	int   mismatches   = 0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// zero acts as one, anything past the window as the full window
	function automatic int eff_len();
		if (length_reg == 0) return 1;
		if (length_reg > WINDOW) return WINDOW;
		return int'(length_reg);
	endfunction

	task automatic clear_region();
		int i;
		for (i = 0; i < WINDOW; i++) win_bytes[i] = 8'h00;
		byte_count = '0;
		hit_count  = '0;
		first_hit  = 1'b0;
	endtask

	task automatic scan_predict(input in_item_t it);
		int          n, i;
		logic        hit, report;
		logic [31:0] start;
		out_item_t   r;
		n = eff_len();
		for (i = WINDOW - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
		win_bytes[0] = it.scanned_byte;
		if (byte_count != 32'hFFFF_FFFF) byte_count++;
		hit = (byte_count >= n);
		for (i = 0; i < n; i++)
			if (care_bits[i] && win_bytes[n-1-i] != pattern_bits[8*i +: 8]) hit = 1'b0;
		report = hit && !(first_mode && first_hit);
		start  = '0;
		if (report) begin
			start     = byte_count - 32'(n);
			first_hit = 1'b1;
			if (hit_count != '1) hit_count++;
		end
		if (!report && !it.last_byte) return;
		r.match_found   = report;
		r.match_offset  = report ? start : '0;
		r.match_address = report ? base_addr + {32'b0, start} : '0;
		r.region_done   = it.last_byte;
		r.match_count   = hit_count;
		results_due = {results_due, r};
		if (it.last_byte) clear_region();
	endtask

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (results_due.size() == 0) begin
			$display("%0t: unexpected item %p", $time, got);
			mismatches++;
			return;
		end
		want = results_due.pop_front();
		report_field("match_found", 64'(want.match_found), 64'(got.match_found));
		report_field("match_offset", 64'(want.match_offset), 64'(got.match_offset));
		report_field("match_address", want.match_address, got.match_address);
		report_field("region_done", 64'(want.region_done), 64'(got.region_done));
		report_field("match_count", 64'(want.match_count), 64'(got.match_count));
	endtask

	// handshakes, prediction, checking and the watchdog, all at the rising edge
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) scan_predict(in_data);
		if (out_valid && !out_stall) check_result(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("masked_byte_pattern_scanner: mismatch");
				$finish;
			end
		end
	end

	// byte driver: hold an offered item until taken, then gap or advance
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (bytes_pending.size() != 0) begin
				in_data  <= bytes_pending.pop_front();
				in_valid <= 1'b1;
				in_gap   <= in_gaps_on ? gap_len() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: long hold-off first, then random stalls
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (out_gap != 0) begin
			out_stall <= 1'b1;
			out_gap   <= out_gap - 1;
		end else begin
			out_stall <= 1'b0;
			out_gap   <= out_gaps_on ? gap_len() : 0;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		case (idx)
			REG_PATTERN_LOW:    pattern_bits[63:0]   = value;
			REG_PATTERN_HIGH:   pattern_bits[127:64] = value;
			REG_CARE_MASK:      care_bits            = value[CARE_BITS-1:0];
			REG_PATTERN_LENGTH: length_reg           = value[LENGTH_BITS-1:0];
			REG_FIRST_ONLY:     first_mode           = value[0];
			REG_BASE_ADDRESS:   base_addr            = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// hold until every item is taken and every result has come, then settle
	task automatic wait_quiet();
		while (bytes_pending.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_region(input logic [7:0] body [$], input bit close);
		int       k;
		in_item_t it;
		for (k = 0; k < body.size(); k++) begin
			it.scanned_byte = body[k];
			it.last_byte    = close && (k == body.size() - 1);
			bytes_pending = {bytes_pending, it};
		end
	endtask

	// region of random bytes with planted pattern copies, wildcards randomised
	task automatic queue_region(input int want_len, input bit close, inout int sent);
		logic [7:0] body [$];
		int         n, k, pick;
		n = eff_len();
		while (body.size() < want_len) begin
			if (body.size() + n <= want_len && $urandom_range(0, 2) == 0) begin
				for (k = 0; k < n; k++)
					body = {body, (care_bits[k] ? pattern_bits[8*k +: 8] : 8'($urandom))};
			end else if ($urandom_range(0, 1) == 0) begin
				pick = $urandom_range(0, n - 1);
				body = {body, pattern_bits[8*pick +: 8]};
			end else begin
				body = {body, 8'($urandom)};
			end
		end
		sent += body.size();
		send_region(body, close);
	endtask

	initial begin
		int                         phase, sent, n, span;
		logic [8*PATTERN_BYTES-1:0] pat;
		logic [CARE_BITS-1:0]       cm;
		logic [LENGTH_BITS-1:0]     len5;
		logic                       first;
		logic [ADDR_BITS-1:0]       base;
		logic [7:0]                 body [$];

		pattern_bits = '0;
		care_bits    = CARE_MASK_RST;
		length_reg   = PATTERN_LENGTH_RST;
		first_mode   = 1'b0;
		base_addr    = '0;
		clear_region();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: single zero byte pattern, matches on the first and last byte
		sent = 0;
		body = '{8'h00, 8'hFF, 8'h00};
		send_region(body, 1'b1);
		body = '{8'hFF};
		send_region(body, 1'b1);
		wait_quiet();

		// DE AD ?? EF with a wildcard in the third byte
		write_reg(REG_PATTERN_LOW, 64'h0000_0000_EF00_ADDE);
		write_reg(REG_CARE_MASK, 64'h0000_0000_0000_000B);
		write_reg(REG_PATTERN_LENGTH, 64'd4);
		write_reg(REG_BASE_ADDRESS, 64'h0000_0000_1000_0000);
		body = '{8'hDE, 8'hAD, 8'h55, 8'hEF, 8'h00, 8'hDE, 8'hAD, 8'h00, 8'hEF};
		send_region(body, 1'b1);
		// region shorter than the pattern
		body = '{8'hDE, 8'hAD, 8'h55};
		send_region(body, 1'b1);
		wait_quiet();
		write_reg(REG_FIRST_ONLY, 64'd1);
		body = '{8'hDE, 8'hAD, 8'h11, 8'hEF, 8'hDE, 8'hAD, 8'h22, 8'hEF};
		send_region(body, 1'b1);
		wait_quiet();

		// every byte matches; hold results off so the block backs up
		write_reg(REG_CARE_MASK, 64'd0);
		write_reg(REG_PATTERN_LENGTH, 64'd1);
		write_reg(REG_FIRST_ONLY, 64'd0);
		@(posedge clk);
		hold_left = 300;
		queue_region(60, 1'b1, sent);
		wait_quiet();

		for (phase = 0; phase < 24; phase++) begin
			wait_quiet();
			pat   = {rand64(), rand64()};
			cm    = 16'($urandom) | 16'($urandom);
			len5  = 5'($urandom_range(1, 16));
			first = ($urandom_range(0, 2) == 0);
			base  = rand64();
			case (phase)
				0: begin
					len5 = 5'd16;
					cm   = 16'hFFFF;
					base = '1;
				end
				1: len5 = 5'd0;
				2: begin
					len5 = 5'd31;
					cm   = 16'h0000;
				end
				3: begin
					len5  = 5'd17;
					first = 1'b1;
				end
				4: base = '0;
				default: ;
			endcase
			write_reg(REG_PATTERN_LOW, pat[63:0]);
			write_reg(REG_PATTERN_HIGH, pat[127:64]);
			write_reg(REG_CARE_MASK, (rand64() << CARE_BITS) | 64'(cm));
			write_reg(REG_PATTERN_LENGTH, (rand64() << LENGTH_BITS) | 64'(len5));
			write_reg(REG_FIRST_ONLY, (rand64() << 1) | 64'(first));
			write_reg(REG_BASE_ADDRESS, base);
			in_gaps_on  = ($urandom_range(0, 3) != 0);
			out_gaps_on = ($urandom_range(0, 3) != 0);
			n    = eff_len();
			sent = 0;
			while (sent < 58) begin
				case ($urandom_range(0, 7))
					0: span = $urandom_range(1, n);
					1: span = $urandom_range(20, 64);
					default: span = $urandom_range(1, 3 * n + 8);
				endcase
				queue_region(span, 1'b1, sent);
			end
			// leave a region open across the next settings change
			if (phase % 4 == 3) queue_region($urandom_range(1, 2 * n), 1'b0, sent);
		end
		queue_region(10, 1'b1, sent);
		wait_quiet();
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("masked_byte_pattern_scanner: match");
		end else begin
			$display("masked_byte_pattern_scanner: mismatch");
		end
		$finish;
	end

endmodule

### masked_byte_pattern_scanner.f
design/mbps_pkg.sv
design/mbps_window.sv
design/mbps_match.sv
design/masked_byte_pattern_scanner.sv
bench/tb_masked_byte_pattern_scanner.sv
